### rtl/stepper_uart_write_frame_assert.svh
`ifndef STEPPER_UART_WRITE_FRAME_ASSERT_SVH
`define STEPPER_UART_WRITE_FRAME_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SUWF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stepper_uart_write_frame: check failed");

// Next-cycle implication, checked outside reset.
`define SUWF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stepper_uart_write_frame: check failed");

// Next-cycle implication, checked during reset as well.
`define SUWF_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("stepper_uart_write_frame: check failed");

`endif

### rtl/suwf_pkg.sv
package suwf_pkg;

   localparam int FRAME_LEN = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] SYNC_BYTE = 8'h05;
   localparam logic [7:0] WRITE_FLAG = 8'h80;
   localparam logic [7:0] CRC_POLY = 8'h07;

   typedef logic [7:0] byte_type;
   typedef logic [2:0] byte_index_type;

   localparam byte_index_type LAST_INDEX = byte_index_type'(FRAME_LEN - 1);

   typedef enum byte_index_type {
      IDX_SYNC   = 3'd0,
      IDX_NODE   = 3'd1,
      IDX_REG    = 3'd2,
      IDX_DATA3  = 3'd3,
      IDX_DATA2  = 3'd4,
      IDX_DATA1  = 3'd5,
      IDX_DATA0  = 3'd6,
      IDX_CRC    = 3'd7
   } byte_slot_type;

   typedef struct packed {
      logic [1:0] node_address;
      logic [6:0] register_address;
      logic [31:0] write_data;
   } frame_type;

   // Byte of the datagram header and body at a given slot; the CRC slot is
   // supplied by the sender.
   function automatic byte_type frame_byte_at(frame_type frame, byte_index_type idx);
      byte_type result;
      result = '0;
      unique case (byte_slot_type'(idx))
         IDX_SYNC:  result = SYNC_BYTE;
         IDX_NODE:  result = {6'd0, frame.node_address};
         IDX_REG:   result = WRITE_FLAG | {1'b0, frame.register_address};
         IDX_DATA3: result = frame.write_data[31:24];
         IDX_DATA2: result = frame.write_data[23:16];
         IDX_DATA1: result = frame.write_data[15:8];
         IDX_DATA0: result = frame.write_data[7:0];
         IDX_CRC:   result = '0;
         default:   result = '0;
      endcase
      return result;
   endfunction

   // One byte through the CRC-8, least significant bit first.
   function automatic byte_type crc8_step(byte_type crc, byte_type data);
      byte_type c;
      byte_type d;
      c = crc;
      d = data;
      for (int b = 0; b < 8; b++) begin
         if (c[7] ^ d[0]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
         d = {1'b0, d[7:1]};
      end
      return c;
   endfunction

endpackage

### rtl/stepper_uart_write_frame.sv
// A write passes the front stage register, the queue, the frame register and the output
// byte register before its first byte is shown. Bytes leave at one per cycle unless
// rsp_pop stalls, set by the single byte-wide result register that the frame sender drives.
// A two-entry queue lets new writes be taken while the previous datagram is sent.
// Reset is synchronous: node address returns to 0 and all queued words are dropped.
module stepper_uart_write_frame (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [6:0]  req_register_address,
   input  logic [31:0] req_write_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_last_byte,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);
   import suwf_pkg::*;

   logic f_push;
   logic f_ready;
   frame_type f_frame;
   logic b_valid;
   logic b_pop;
   frame_type b_frame;

   suwf_front u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_register_address(req_register_address),
      .req_write_data(req_write_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .q_push(f_push),
      .q_ready(f_ready),
      .q_frame(f_frame)
   );

   suwf_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(f_push),
      .ready(f_ready),
      .push_frame(f_frame),
      .valid(b_valid),
      .pop(b_pop),
      .pop_frame(b_frame)
   );

   suwf_back u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(b_valid),
      .q_pop(b_pop),
      .q_frame(b_frame),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_last_byte(rsp_last_byte)
   );

endmodule

### rtl/suwf_front.sv
module suwf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [6:0]        req_register_address,
   input  logic [31:0]       req_write_data,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_wr_data,
   output logic              q_push,
   input  logic              q_ready,
   output suwf_pkg::frame_type q_frame
);
   import suwf_pkg::*;

   logic [1:0] node_ff;
   logic [1:0] node_in;
   logic stage_valid_ff;
   logic stage_valid_in;
   frame_type stage_ff;
   frame_type stage_in;
   logic accept;

   assign req_full = stage_valid_ff && !q_ready;
   assign accept = req_push && !req_full;
   assign q_push = stage_valid_ff;
   assign q_frame = stage_ff;

   always_comb begin
      node_in = csr_wr_en ? csr_wr_data : node_ff;
      stage_in = stage_ff;
      stage_valid_in = stage_valid_ff;
      if (stage_valid_ff && q_ready) begin
         stage_valid_in = 1'b0;
      end
      if (accept) begin
         stage_valid_in = 1'b1;
         stage_in.node_address = node_ff;
         stage_in.register_address = req_register_address;
         stage_in.write_data = req_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         node_ff <= node_in;
         stage_valid_ff <= stage_valid_in;
      end
      stage_ff <= stage_in;
   end

endmodule

### rtl/suwf_queue.sv
module suwf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                ready,
   input  suwf_pkg::frame_type push_frame,
   output logic                valid,
   input  logic                pop,
   output suwf_pkg::frame_type pop_frame
);
   import suwf_pkg::*;

   frame_type store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic do_push;
   logic do_pop;

   assign ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign valid = count_ff != '0;
   assign do_push = push && ready;
   assign do_pop = pop && valid;
   assign pop_frame = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

### rtl/suwf_back.sv
module suwf_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_pop,
   input  suwf_pkg::frame_type q_frame,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [7:0]          rsp_frame_byte,
   output logic                rsp_last_byte
);
   import suwf_pkg::*;

   frame_type frame_ff;
   frame_type frame_in;
   logic busy_ff;
   logic busy_in;
   byte_index_type idx_ff;
   byte_index_type idx_in;
   byte_type crc_ff;
   byte_type crc_in;
   logic out_valid_ff;
   logic out_valid_in;
   byte_type out_byte_ff;
   byte_type out_byte_in;
   logic out_last_ff;
   logic out_last_in;
   logic advance;
   logic at_last;
   byte_type body_byte;

   assign advance = !out_valid_ff || rsp_pop;
   assign at_last = idx_ff == LAST_INDEX;
   assign body_byte = frame_byte_at(frame_ff, idx_ff);
   assign q_pop = q_valid && (!busy_ff || (advance && at_last));

   assign rsp_empty = !out_valid_ff;
   assign rsp_frame_byte = out_byte_ff;
   assign rsp_last_byte = out_last_ff;

   always_comb begin
      frame_in = frame_ff;
      busy_in = busy_ff;
      idx_in = idx_ff;
      crc_in = crc_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      if (busy_ff && advance) begin
         out_valid_in = 1'b1;
         if (at_last) begin
            out_byte_in = crc_ff;
            out_last_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            out_byte_in = body_byte;
            out_last_in = 1'b0;
            crc_in = crc8_step(crc_ff, body_byte);
            idx_in = idx_ff + byte_index_type'(1);
         end
      end
      if (q_pop) begin
         frame_in = q_frame;
         busy_in = 1'b1;
         idx_in = '0;
         crc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         out_valid_ff <= out_valid_in;
         idx_ff <= idx_in;
      end
      frame_ff <= frame_in;
      crc_ff <= crc_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

endmodule

### rtl/suwf_checker.sv
`include "stepper_uart_write_frame_assert.svh"

module suwf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [7:0]  rsp_frame_byte,
   input logic        rsp_last_byte
);
   import suwf_pkg::*;

   byte_index_type pos_ff;
   byte_index_type pos_in;
   logic rsp_taken;
   logic rsp_waiting;
   logic [8:0] rsp_word;
   logic at_sync;
   logic at_reg;

   assign rsp_taken = rsp_pop && !rsp_empty;
   assign rsp_waiting = !rsp_empty && !rsp_pop;
   assign rsp_word = {rsp_last_byte, rsp_frame_byte};
   assign at_sync = !rsp_empty && pos_ff == '0;
   assign at_reg = !rsp_empty && pos_ff == byte_index_type'(IDX_REG);

   always_comb begin
      pos_in = pos_ff;
      if (rsp_taken) begin
         pos_in = rsp_last_byte ? '0 : pos_ff + byte_index_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   `SUWF_ASSERT_ALWAYS_NEXT(a_reset_clears, clock, reset, rsp_empty && !req_full)
   `SUWF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_waiting, !rsp_empty && $stable(rsp_word))
   `SUWF_ASSERT_NOW(a_sync_first, clock, reset, at_sync, rsp_frame_byte == SYNC_BYTE && !rsp_last_byte)
   `SUWF_ASSERT_NOW(a_last_is_eighth, clock, reset, !rsp_empty, rsp_last_byte == (pos_ff == LAST_INDEX))
   `SUWF_ASSERT_NOW(a_write_flag, clock, reset, at_reg, rsp_frame_byte[7])

endmodule

bind stepper_uart_write_frame suwf_checker u_checker (.*);

### dv/stepper_uart_write_frame_tb.sv
module stepper_uart_write_frame_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import suwf_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_LIMIT = 10;
   localparam int RANDOM_PER_PHASE = 66;

   typedef struct packed {
      byte_type frame_byte;
      logic     last_byte;
   } datagram_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [6:0]  req_register_address = '0;
   logic [31:0] req_write_data = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_last_byte;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_wr_data = '0;

   datagram_word_type expected_words[$];
   datagram_word_type oldest_word;
   logic [1:0]     node_shadow = '0;
   int             send_idle_pct = 0;
   int             pop_stall_pct = 0;
   int             mismatches = 0;
   int             datagrams_sent = 0;
   int             words_checked = 0;

   stepper_uart_write_frame u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_register_address (req_register_address),
      .req_write_data       (req_write_data),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_frame_byte       (rsp_frame_byte),
      .rsp_last_byte        (rsp_last_byte),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   always #1 clock = ~clock;

   // The CRC takes each byte least significant bit first.
   function automatic byte_type crc_feed_byte(byte_type crc, byte_type data);
      byte_type acc;
      acc = crc;
      for (int b = 0; b < 8; b++) begin
         if (acc[7] != data[b]) begin
            acc = (acc << 1) ^ CRC_POLY;
         end else begin
            acc = acc << 1;
         end
      end
      return acc;
   endfunction

   task automatic predict_datagram(input logic [6:0] reg_addr, input logic [31:0] data);
      byte_type body[FRAME_LEN];
      byte_type crc;
      datagram_word_type word;
      body[0] = SYNC_BYTE;
      body[1] = {6'd0, node_shadow};
      body[2] = WRITE_FLAG | {1'b0, reg_addr};
      body[3] = data[31:24];
      body[4] = data[23:16];
      body[5] = data[15:8];
      body[6] = data[7:0];
      crc = '0;
      for (int k = 0; k < FRAME_LEN - 1; k++) begin
         crc = crc_feed_byte(crc, body[k]);
      end
      body[FRAME_LEN - 1] = crc;
      for (int k = 0; k < FRAME_LEN; k++) begin
         word.frame_byte = body[k];
         word.last_byte = (k == FRAME_LEN - 1);
         expected_words = {expected_words, word};
      end
   endtask

   task automatic log_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("MISMATCH %s: expected 0x%0h, got 0x%0h at word %0d",
                  what, want, got, words_checked);
      end
   endtask

   task automatic send_write(input logic [6:0] reg_addr, input logic [31:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_register_address <= reg_addr;
      req_write_data <= data;
      do @(posedge clock); while (req_full);
      predict_datagram(reg_addr, data);
      datagrams_sent++;
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_node(input logic [1:0] addr);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= addr;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      node_shadow = addr;
   endtask

   task automatic test_directed_fields();
      set_node(2'd0);
      send_write(7'h00, 32'h0000_0000);
      send_write(7'h7F, 32'hFFFF_FFFF);
      send_write(7'h55, 32'hAAAA_AAAA);
      send_write(7'h2A, 32'h5555_5555);
      send_write(7'h01, 32'h0000_0001);
      send_write(7'h40, 32'h8000_0000);
      send_write(7'h00, 32'h0000_00FF);
      send_write(7'h7F, 32'hFF00_0000);
   endtask

   task automatic test_node_addresses();
      logic [1:0] nodes[4] = '{2'd3, 2'd1, 2'd2, 2'd0};
      foreach (nodes[i]) begin
         set_node(nodes[i]);
         send_write(7'h7F, 32'hFFFF_FFFF);
         send_write(7'h00, 32'h0000_0000);
      end
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input logic [1:0] node);
      logic [31:0] data;
      set_node(node);
      send_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
         // Midway through, hold off until the output side has fully drained.
         if (i == RANDOM_PER_PHASE / 2) begin
            wait_idle();
         end
         case ($urandom_range(7))
            0: data = 32'h0000_0000;
            1: data = 32'hFFFF_FFFF;
            2: data = 32'h1 << $urandom_range(31);
            default: data = $urandom;
         endcase
         send_write(7'($urandom_range(127)), data);
      end
      wait_idle();
      send_idle_pct = 0;
      pop_stall_pct = 0;
   endtask

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_words.size() == 0) begin
            log_mismatch("unexpected word", 0, 32'({rsp_last_byte, rsp_frame_byte}));
         end else begin
            oldest_word = expected_words.pop_front();
            if (rsp_frame_byte !== oldest_word.frame_byte) begin
               log_mismatch("frame_byte", 32'(oldest_word.frame_byte), 32'(rsp_frame_byte));
            end
            if (rsp_last_byte !== oldest_word.last_byte) begin
               log_mismatch("last_byte", 32'(oldest_word.last_byte), 32'(rsp_last_byte));
            end
         end
         words_checked++;
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timed out with %0d words outstanding.", expected_words.size());
      $display("stepper_uart_write_frame regression: fail");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_fields();
      test_node_addresses();
      test_random_traffic(0, 0, 2'd3);
      test_random_traffic(48, 0, 2'd1);
      test_random_traffic(0, 48, 2'd2);
      test_random_traffic(37, 37, 2'd0);
      wait_idle();
      $display("Sent %0d write datagrams and checked %0d bytes against the prediction.",
               datagrams_sent, words_checked);
      $display("Node addresses 0 to 3 were used, with and without idle and stall cycles.");
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("stepper_uart_write_frame regression: pass");
      end else begin
         $display("stepper_uart_write_frame regression: fail");
      end
      $finish;
   end

endmodule
